>>> rtl/dvasd_pkg.sv
// shared types and constants for the dv audio sample decoder
`timescale 1ns / 1ps
`default_nettype none
package dvasd_pkg;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int SLOT_W   = 6;
   localparam int BASE_W   = 7;
   localparam int SAMPLE_W = 16;
   localparam int CODE_W   = 12;
   localparam int POS_W    = 12;
   localparam int SEQ_W    = 4;
   localparam int STRIDE_W = 8;
   localparam int FULL_W   = SLOT_W + STRIDE_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEQ   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 2'd2;

   // register reset values
   localparam logic              RESET_MODE  = 1'b0;
   localparam logic [SEQ_W-1:0]  RESET_SEQ   = 4'd10;
   localparam logic [POS_W-1:0]  RESET_LIMIT = 12'd3200;

   // positions per dif sequence within one slot
   localparam int                  SLOT_STRIDE  = 9;
   localparam logic [STRIDE_W-1:0] RESET_STRIDE = STRIDE_W'(10 * SLOT_STRIDE);

   // nonlinear curve segment boundaries
   localparam logic [CODE_W-1:0] CODE_LINEAR_TOP = 12'h200;
   localparam logic [CODE_W-1:0] CODE_ZERO       = 12'h800;
   localparam logic [CODE_W-1:0] CODE_NEG_TAIL   = 12'he00;
   localparam logic [3:0]        NEG_SHIFT_BASE  = 4'd14;

   // most negative linear sample, remapped to zero
   localparam logic [SAMPLE_W-1:0] SAMPLE_MOST_NEG = 16'h8000;

   // position and in-range flag for one sample
   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             valid;
   } pos_result_type;

endpackage
`default_nettype wire

>>> rtl/dv_audio_sample_decoder.sv
// top level of the dv audio sample decoder
`timescale 1ns / 1ps
`default_nettype none
// Decodes one three-byte dv audio group per transaction. A transaction is taken on any
// cycle where start is high (busy stays low), so one group per clock is sustained. The
// result is shown for a single cycle, marked by rsp_strobe, after it passes through the
// input register and then the result register, with the code expansion and the
// slot-offset multiply between them. The receiver cannot stall the result, so it must
// capture every strobe. Registers on the csr port (0 mode, 1 sequence count, 2 sample
// limit) are taken on any cycle and must only be written while no transaction is in flight.
module dv_audio_sample_decoder (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [dvasd_pkg::BYTE_W-1:0]        req_first_byte,
   input  wire logic [dvasd_pkg::BYTE_W-1:0]        req_second_byte,
   input  wire logic [dvasd_pkg::BYTE_W-1:0]        req_third_byte,
   input  wire logic [dvasd_pkg::SLOT_W-1:0]        req_slot_index,
   input  wire logic [dvasd_pkg::BASE_W-1:0]        req_base_first,
   input  wire logic [dvasd_pkg::BASE_W-1:0]        req_base_second,
   // response
   output logic                                     rsp_strobe,
   output logic signed [dvasd_pkg::SAMPLE_W-1:0]    rsp_sample_first,
   output logic      [dvasd_pkg::POS_W-1:0]         rsp_position_first,
   output logic                                     rsp_valid_first,
   output logic signed [dvasd_pkg::SAMPLE_W-1:0]    rsp_sample_second,
   output logic      [dvasd_pkg::POS_W-1:0]         rsp_position_second,
   output logic                                     rsp_valid_second,
   // configuration
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [dvasd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [dvasd_pkg::CSR_DATA_W-1:0]    csr_data
);

   // configuration registers
   logic                               mode_ff;
   logic [dvasd_pkg::STRIDE_W-1:0]     stride_ff;
   logic [dvasd_pkg::STRIDE_W-1:0]     stride_in;
   logic [dvasd_pkg::POS_W-1:0]        limit_ff;

   // input register
   logic                               s1_valid_ff;
   logic [dvasd_pkg::BYTE_W-1:0]       s1_b0_ff;
   logic [dvasd_pkg::BYTE_W-1:0]       s1_b1_ff;
   logic [dvasd_pkg::BYTE_W-1:0]       s1_b2_ff;
   logic [dvasd_pkg::SLOT_W-1:0]       s1_slot_ff;
   logic [dvasd_pkg::BASE_W-1:0]       s1_base_a_ff;
   logic [dvasd_pkg::BASE_W-1:0]       s1_base_b_ff;

   // decode logic
   logic                               accept;
   logic [dvasd_pkg::CODE_W-1:0]       code_a;
   logic [dvasd_pkg::CODE_W-1:0]       code_b;
   logic [dvasd_pkg::SAMPLE_W-1:0]     exp_a;
   logic [dvasd_pkg::SAMPLE_W-1:0]     exp_b;
   logic [dvasd_pkg::SAMPLE_W-1:0]     linear;
   logic [dvasd_pkg::FULL_W-1:0]       slot_offset;
   dvasd_pkg::pos_result_type          pos_a;
   dvasd_pkg::pos_result_type          pos_b;
   logic [dvasd_pkg::SAMPLE_W-1:0]     samp_a_in;
   logic [dvasd_pkg::SAMPLE_W-1:0]     samp_b_in;
   dvasd_pkg::pos_result_type          pos_b_in;

   // result register
   logic                               rsp_strobe_ff;
   logic [dvasd_pkg::SAMPLE_W-1:0]     samp_a_ff;
   logic [dvasd_pkg::SAMPLE_W-1:0]     samp_b_ff;
   dvasd_pkg::pos_result_type          pos_a_ff;
   dvasd_pkg::pos_result_type          pos_b_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // slot stride kept premultiplied by the sequence count
   assign stride_in = dvasd_pkg::STRIDE_W'(csr_data[dvasd_pkg::SEQ_W-1:0])
                      * dvasd_pkg::STRIDE_W'(dvasd_pkg::SLOT_STRIDE);

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= dvasd_pkg::RESET_MODE;
         stride_ff <= dvasd_pkg::RESET_STRIDE;
         limit_ff  <= dvasd_pkg::RESET_LIMIT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dvasd_pkg::CSR_MODE: begin
               mode_ff <= csr_data[0];
            end
            dvasd_pkg::CSR_SEQ: begin
               stride_ff <= stride_in;
            end
            dvasd_pkg::CSR_LIMIT: begin
               limit_ff <= csr_data[dvasd_pkg::POS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_b0_ff     <= req_first_byte;
         s1_b1_ff     <= req_second_byte;
         s1_b2_ff     <= req_third_byte;
         s1_slot_ff   <= req_slot_index;
         s1_base_a_ff <= req_base_first;
         s1_base_b_ff <= req_base_second;
      end
   end

   // split the group into two 12-bit codes
   assign code_a = {s1_b0_ff, s1_b2_ff[7:4]};
   assign code_b = {s1_b1_ff, s1_b2_ff[3:0]};

   dvasd_expand u_expand_a (
      .code   (code_a),
      .sample (exp_a)
   );

   dvasd_expand u_expand_b (
      .code   (code_b),
      .sample (exp_b)
   );

   // slot offset shared by both positions
   assign slot_offset = dvasd_pkg::FULL_W'(s1_slot_ff) * dvasd_pkg::FULL_W'(stride_ff);

   dvasd_position u_position_a (
      .base        (s1_base_a_ff),
      .slot_offset (slot_offset),
      .limit       (limit_ff),
      .result      (pos_a)
   );

   dvasd_position u_position_b (
      .base        (s1_base_b_ff),
      .slot_offset (slot_offset),
      .limit       (limit_ff),
      .result      (pos_b)
   );

   // linear big-endian sample, most negative value forced to zero
   assign linear = ({s1_b0_ff, s1_b1_ff} == dvasd_pkg::SAMPLE_MOST_NEG) ?
                   '0 : {s1_b0_ff, s1_b1_ff};

   // mode select
   always_comb begin
      if (mode_ff) begin
         samp_a_in = exp_a;
         samp_b_in = exp_b;
         pos_b_in  = pos_b;
      end else begin
         samp_a_in = linear;
         samp_b_in = '0;
         pos_b_in  = '0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s1_valid_ff;
      end
      if (s1_valid_ff) begin
         samp_a_ff <= samp_a_in;
         samp_b_ff <= samp_b_in;
         pos_a_ff  <= pos_a;
         pos_b_ff  <= pos_b_in;
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_sample_first    = samp_a_ff;
   assign rsp_position_first  = pos_a_ff.pos;
   assign rsp_valid_first     = pos_a_ff.valid;
   assign rsp_sample_second   = samp_b_ff;
   assign rsp_position_second = pos_b_ff.pos;
   assign rsp_valid_second    = pos_b_ff.valid;

   // every accepted transaction gives a strobe once it has passed the input and result registers
   a_accept_to_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe)
      else $error("accepted transaction produced no result");

   // no strobe without an earlier transaction that passed the input and result registers
   a_no_spurious_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 2))
      else $error("result strobe without a transaction");

   // linear mode leaves the second sample empty
   a_linear_second_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !mode_ff |-> (rsp_valid_second == 1'b0) && (rsp_sample_second == '0)
                                 && (rsp_position_second == '0))
      else $error("second sample populated in 16-bit mode");

endmodule
`default_nettype wire

>>> rtl/dvasd_expand.sv
// expansion of one 12-bit nonlinear dv code to a 16-bit sample
`timescale 1ns / 1ps
`default_nettype none
module dvasd_expand (
   input  wire logic [dvasd_pkg::CODE_W-1:0]   code,
   output logic      [dvasd_pkg::SAMPLE_W-1:0] sample
);

   logic [7:0]                    mant;
   logic [3:0]                    expo;
   logic [2:0]                    pos_sh;
   logic [2:0]                    neg_sh;
   logic [3:0]                    neg_sh_full;
   logic [dvasd_pkg::SAMPLE_W-1:0] pos_val;
   logic [dvasd_pkg::SAMPLE_W-1:0] neg_val;
   logic [dvasd_pkg::SAMPLE_W-1:0] tail_val;

   assign mant = code[7:0];
   assign expo = code[11:8];

   // positive segments: implied leading one, shift by exponent less one
   assign pos_sh  = expo[2:0] - 3'd1;
   assign pos_val = {7'd0, 1'b1, mant} << pos_sh;

   // negative segments: mantissa less 256, scaled down the curve, less one
   assign neg_sh_full = dvasd_pkg::NEG_SHIFT_BASE - expo;
   assign neg_sh      = neg_sh_full[2:0];
   assign neg_val     = ({8'hff, mant} << neg_sh) - 16'd1;

   // small negative tail is the code taken as 12-bit two's complement
   assign tail_val = {{4{code[11]}}, code};

   // segment select
   always_comb begin
      if (code < dvasd_pkg::CODE_LINEAR_TOP) begin
         sample = {4'd0, code};
      end else if (code < dvasd_pkg::CODE_ZERO) begin
         sample = pos_val;
      end else if (code == dvasd_pkg::CODE_ZERO) begin
         sample = '0;
      end else if (code < dvasd_pkg::CODE_NEG_TAIL) begin
         sample = neg_val;
      end else begin
         sample = tail_val;
      end
   end

endmodule
`default_nettype wire

>>> rtl/dvasd_position.sv
// frame position of one sample and its in-range flag
`timescale 1ns / 1ps
`default_nettype none
module dvasd_position (
   input  wire logic [dvasd_pkg::BASE_W-1:0] base,
   input  wire logic [dvasd_pkg::FULL_W-1:0] slot_offset,
   input  wire logic [dvasd_pkg::POS_W-1:0]  limit,
   output dvasd_pkg::pos_result_type         result
);

   logic [dvasd_pkg::FULL_W-1:0] full_pos;

   // full precision sum, compared before truncation
   assign full_pos     = slot_offset + dvasd_pkg::FULL_W'(base);
   assign result.pos   = full_pos[dvasd_pkg::POS_W-1:0];
   assign result.valid = full_pos < dvasd_pkg::FULL_W'(limit);

endmodule
`default_nettype wire
